### rtl/midi_channel_fanout_router_defines.svh
// Assertion helpers used by the router top level
`ifndef MIDI_CHANNEL_FANOUT_ROUTER_DEFINES_SVH
`define MIDI_CHANNEL_FANOUT_ROUTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MCFR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define MCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/mcfr_pkg.sv
package mcfr_pkg;

   localparam int CHANNELS = 16;
   localparam int CH_BITS  = $clog2(CHANNELS);

   typedef logic [CHANNELS-1:0] mask_type;

   // config register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAKER_ID   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_SKIP  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_ADD   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_RESET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_CLEAR = 3'd4;

   localparam logic [7:0] RST_MAKER_ID   = 8'd125;
   localparam logic [7:0] RST_CODE_SKIP  = 8'd0;
   localparam logic [7:0] RST_CODE_ADD   = 8'd1;
   localparam logic [7:0] RST_CODE_RESET = 8'd2;
   localparam logic [7:0] RST_CODE_CLEAR = 8'd3;

   localparam logic [7:0] STATUS_SYSTEM = 8'hF0;
   localparam logic [7:0] SX_START      = 8'hF0;
   localparam logic [7:0] SX_END        = 8'hF7;
   localparam logic [7:0] SX_MIN_LEN    = 8'd4;
   localparam logic [7:0] SKIP_LEN      = 8'd7;
   localparam logic [7:0] ADD_LEN       = 8'd6;

   typedef struct packed {
      logic capture;   // latch the incoming item
      logic decode;    // classify item, update matrix, load pending set
      logic load_out;  // move next pending result into the output register
   } cmd_type;

   typedef struct packed {
      logic pend_empty;
      logic last;
   } stat_type;

endpackage

### rtl/mcfr_ctrl.sv
module mcfr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mcfr_pkg::cmd_type  cmd,
   input  mcfr_pkg::stat_type stat
);
   import mcfr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DECODE = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   assign cmd.capture  = accept;
   assign cmd.decode   = (state_ff == ST_DECODE);
   assign cmd.load_out = (state_ff == ST_EMIT) & ~stat.pend_empty & out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.pend_empty) state_in = ST_IDLE;
            else if (out_free && stat.last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/mcfr_datapath.sv
module mcfr_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [7:0]                     req_status_byte,
   input  logic [7:0]                     req_data_one,
   input  logic [7:0]                     req_data_two,
   input  logic [7:0]                     req_sx_length,
   input  logic [7:0]                     req_sx_first,
   input  logic [7:0]                     req_sx_maker,
   input  logic [7:0]                     req_sx_command,
   input  logic [7:0]                     req_sx_arg_a,
   input  logic [7:0]                     req_sx_arg_b,
   input  logic [7:0]                     req_sx_arg_c,
   input  logic [7:0]                     req_sx_final,
   input  logic                           csr_we,
   input  logic [mcfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_wdata,
   input  mcfr_pkg::cmd_type              cmd,
   output mcfr_pkg::stat_type             stat,
   output logic [7:0]                     rsp_out_status,
   output logic [7:0]                     rsp_out_data_one,
   output logic [7:0]                     rsp_out_data_two,
   output logic                           rsp_forward_whole,
   output logic                           rsp_last_of_run
);
   import mcfr_pkg::*;

   // config registers
   logic [7:0] maker_id_ff, code_skip_ff, code_add_ff, code_reset_ff, code_clear_ff;

   // captured item
   logic [7:0] cap_st_ff, cap_d1_ff, cap_d2_ff, cap_len_ff, cap_first_ff, cap_maker_ff;
   logic [7:0] cap_cmd_ff, cap_a_ff, cap_b_ff, cap_c_ff, cap_fin_ff;

   // routing matrix: entry s holds the target set of source channel s
   mask_type mask_ff [CHANNELS];
   mask_type mask_in [CHANNELS];

   // decoded event
   mask_type   pend_ff, pend_in, pend_dec;
   logic [7:0] ev_st_ff, ev_d1_ff, ev_d2_ff;
   logic [7:0] ev_st_dec, ev_d1_dec, ev_d2_dec;
   logic       fan_ff, fan_dec;
   logic       whole_ff, whole_dec;
   logic       act_add, act_reset, act_clear;
   logic       not_cmd;

   // emit side
   mask_type           low_bit;
   logic [CH_BITS-1:0] tgt;

   always_ff @(posedge clock) begin
      if (reset) begin
         maker_id_ff   <= RST_MAKER_ID;
         code_skip_ff  <= RST_CODE_SKIP;
         code_add_ff   <= RST_CODE_ADD;
         code_reset_ff <= RST_CODE_RESET;
         code_clear_ff <= RST_CODE_CLEAR;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAKER_ID:   maker_id_ff   <= csr_wdata;
            CSR_CODE_SKIP:  code_skip_ff  <= csr_wdata;
            CSR_CODE_ADD:   code_add_ff   <= csr_wdata;
            CSR_CODE_RESET: code_reset_ff <= csr_wdata;
            CSR_CODE_CLEAR: code_clear_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cap_st_ff    <= req_status_byte;
         cap_d1_ff    <= req_data_one;
         cap_d2_ff    <= req_data_two;
         cap_len_ff   <= req_sx_length;
         cap_first_ff <= req_sx_first;
         cap_maker_ff <= req_sx_maker;
         cap_cmd_ff   <= req_sx_command;
         cap_a_ff     <= req_sx_arg_a;
         cap_b_ff     <= req_sx_arg_b;
         cap_c_ff     <= req_sx_arg_c;
         cap_fin_ff   <= req_sx_final;
      end
   end

   assign not_cmd = (cap_len_ff < SX_MIN_LEN) || (cap_first_ff != SX_START) ||
                    (cap_fin_ff != SX_END) || (cap_maker_ff != maker_id_ff);

   always_comb begin
      pend_dec  = '0;
      ev_st_dec = cap_st_ff;
      ev_d1_dec = cap_d1_ff;
      ev_d2_dec = cap_d2_ff;
      fan_dec   = 1'b0;
      whole_dec = 1'b0;
      act_add   = 1'b0;
      act_reset = 1'b0;
      act_clear = 1'b0;
      if (cap_len_ff == 8'd0) begin
         if (cap_st_ff < STATUS_SYSTEM) begin
            pend_dec = mask_ff[cap_st_ff[CH_BITS-1:0]];
            fan_dec  = 1'b1;
         end else begin
            pend_dec  = mask_type'(1);
            whole_dec = 1'b1;
         end
      end else if (not_cmd) begin
         pend_dec  = mask_type'(1);
         whole_dec = 1'b1;
      end else if (cap_cmd_ff == code_skip_ff) begin
         // embedded event goes out raw, only for the exact skip length
         ev_st_dec = cap_a_ff;
         ev_d1_dec = cap_b_ff;
         ev_d2_dec = cap_c_ff;
         if (cap_len_ff == SKIP_LEN) pend_dec = mask_type'(1);
      end else if (cap_cmd_ff == code_add_ff) begin
         act_add = (cap_len_ff == ADD_LEN) && (cap_a_ff < 8'(CHANNELS)) &&
                   (cap_b_ff < 8'(CHANNELS));
      end else if (cap_cmd_ff == code_reset_ff) begin
         act_reset = 1'b1;
      end else if (cap_cmd_ff == code_clear_ff) begin
         act_clear = 1'b1;
      end
   end

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         mask_in[i] = mask_ff[i];
         if (cmd.decode) begin
            if (act_clear) begin
               mask_in[i] = '0;
            end else if (act_reset) begin
               mask_in[i][i] = 1'b1;
            end else if (act_add && (cap_a_ff[CH_BITS-1:0] == CH_BITS'(i))) begin
               mask_in[i][cap_b_ff[CH_BITS-1:0]] = 1'b1;
            end
         end
      end
   end

   // pending targets go out lowest channel first
   assign low_bit = pend_ff & (~pend_ff + mask_type'(1));

   always_comb begin
      tgt = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (low_bit[i]) tgt = tgt | CH_BITS'(i);
      end
   end

   assign stat.pend_empty = (pend_ff == '0);
   assign stat.last       = ((pend_ff & ~low_bit) == '0);

   always_comb begin
      pend_in = pend_ff;
      if (cmd.decode) pend_in = pend_dec;
      else if (cmd.load_out) pend_in = pend_ff & ~low_bit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            mask_ff[i] <= mask_type'(1) << i;
         end
      end else begin
         pend_ff <= pend_in;
         for (int i = 0; i < CHANNELS; i++) begin
            mask_ff[i] <= mask_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         ev_st_ff <= ev_st_dec;
         ev_d1_ff <= ev_d1_dec;
         ev_d2_ff <= ev_d2_dec;
         fan_ff   <= fan_dec;
         whole_ff <= whole_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_out_status    <= fan_ff ? {ev_st_ff[7:CH_BITS], tgt} : ev_st_ff;
         rsp_out_data_one  <= ev_d1_ff;
         rsp_out_data_two  <= ev_d2_ff;
         rsp_forward_whole <= whole_ff;
         rsp_last_of_run   <= stat.last;
      end
   end

endmodule

### rtl/midi_channel_fanout_router.sv
// Channel  Handshake            Payload
// req      req_valid/req_stall  status, data bytes, sysex length and bytes
// rsp      rsp_valid/rsp_stall  out event, forward_whole, last_of_run
// csr      csr_valid/csr_ready  csr_index, csr_wdata
//
// One item at a time: capture, decode, then one result per cycle from the
// pending target set (up to 16) while the output is not stalled. An item
// with no results goes back to idle from emit. The single output register sets the pace.
// Synchronous reset restores the identity routing and register defaults.
// A stalled result holds the output register; the next item is taken once
// the last result is loaded, even if it is still waiting.
`include "midi_channel_fanout_router_defines.svh"

module midi_channel_fanout_router (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_status_byte,
   input  logic [7:0]                     req_data_one,
   input  logic [7:0]                     req_data_two,
   input  logic [7:0]                     req_sx_length,
   input  logic [7:0]                     req_sx_first,
   input  logic [7:0]                     req_sx_maker,
   input  logic [7:0]                     req_sx_command,
   input  logic [7:0]                     req_sx_arg_a,
   input  logic [7:0]                     req_sx_arg_b,
   input  logic [7:0]                     req_sx_arg_c,
   input  logic [7:0]                     req_sx_final,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_out_status,
   output logic [7:0]                     rsp_out_data_one,
   output logic [7:0]                     rsp_out_data_two,
   output logic                           rsp_forward_whole,
   output logic                           rsp_last_of_run,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [mcfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                     csr_wdata
);
   import mcfr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   mcfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   mcfr_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_status_byte   (req_status_byte),
      .req_data_one      (req_data_one),
      .req_data_two      (req_data_two),
      .req_sx_length     (req_sx_length),
      .req_sx_first      (req_sx_first),
      .req_sx_maker      (req_sx_maker),
      .req_sx_command    (req_sx_command),
      .req_sx_arg_a      (req_sx_arg_a),
      .req_sx_arg_b      (req_sx_arg_b),
      .req_sx_arg_c      (req_sx_arg_c),
      .req_sx_final      (req_sx_final),
      .csr_we            (csr_valid & csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_out_status    (rsp_out_status),
      .rsp_out_data_one  (rsp_out_data_one),
      .rsp_out_data_two  (rsp_out_data_two),
      .rsp_forward_whole (rsp_forward_whole),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   // a result waiting on a stall must never be overwritten
   `MCFR_ASSERT_NOW(a_no_overwrite, cmd.load_out, !(rsp_valid && rsp_stall), "result overwritten")
   `MCFR_ASSERT_NEXT(a_load_shows, cmd.load_out, rsp_valid, "loaded result not presented")
   `MCFR_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall, "item taken while busy")
   `MCFR_ASSERT_NOW(a_no_emit_on_take, cmd.load_out, !(req_valid && !req_stall), "emit during accept")

endmodule
